// ===== hdl/tree_independence_polynomial_defines.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef TREE_INDEPENDENCE_POLYNOMIAL_DEFINES_SVH
`define TREE_INDEPENDENCE_POLYNOMIAL_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define TIP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tip check failed");

// Next-cycle implication, clocked on clk, off while rst is high.
`define TIP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tip check failed");

`endif

// ===== hdl/tip_pkg.sv =====
`default_nettype none
package tip_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int NCOEF        = MAX_VERTICES + 1;
  localparam int LVL_W        = 5;
  localparam int IDX_W        = 6;
  localparam int ADDR_W       = LVL_W + IDX_W;
  localparam int DATA_W       = 32;
  localparam int LEN_W        = 6;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Which polynomial of the parent a multiply-accumulate pass updates
  typedef enum logic {
    MODE_EXCL = 1'b0,
    MODE_INCL = 1'b1
  } mac_mode_t;

  // Sequencer to stack datapath, one command per cycle
  typedef struct packed {
    logic      rd_en;
    logic      mac;
    mac_mode_t mode;
    logic      jf;
    logic      jg;
    addr_t     fa_addr;
    addr_t     fb_addr;
    addr_t     g_addr;
    logic      acc_clr;
    logic      f_we;
    logic      g_we;
    addr_t     wr_addr;
    logic      wr_acc;
    logic      wr_one;
  } tip_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/tip_store.sv =====
`default_nettype none
module tip_store (
  input  logic              clk,
  input  logic              rst,
  input  tip_pkg::tip_cmd_t cmd,
  output tip_pkg::word_t    hsum
);
  import tip_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  word_t     fmem [DEPTH];
  word_t     gmem [DEPTH];
  word_t     q_fa, q_fb, q_g;
  word_t     opa, opb, prod, acc, wr_data;
  logic      jf1, jg1, mac1, v2, v3;
  mac_mode_t mode1;
  logic [2*DATA_W-1:0] full;

  // write data: accumulator or a constant 0/1 for a freshly opened level
  assign wr_data = cmd.wr_acc ? acc : {{(DATA_W-1){1'b0}}, cmd.wr_one};

  // excluded stack: one write, two reads
  always_ff @(posedge clk) begin
    if (cmd.f_we) fmem[cmd.wr_addr] <= wr_data;
    if (cmd.rd_en) begin
      q_fa <= fmem[cmd.fa_addr];
      q_fb <= fmem[cmd.fb_addr];
    end
  end

  // included stack: one write, one read
  always_ff @(posedge clk) begin
    if (cmd.g_we) gmem[cmd.wr_addr] <= wr_data;
    if (cmd.rd_en) q_g <= gmem[cmd.g_addr];
  end

  // read-side tags follow the data
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      jf1   <= cmd.jf;
      jg1   <= cmd.jg;
      mode1 <= cmd.mode;
    end
  end

  assign hsum = (jf1 ? q_fb : '0) + (jg1 ? q_g : '0);

  // operand, product and accumulate stages
  assign full = opa * opb;

  always_ff @(posedge clk) begin
    if (mode1 == MODE_INCL) begin
      opa <= q_g;
      opb <= q_fb;
    end else begin
      opa <= q_fa;
      opb <= hsum;
    end
    prod <= full[DATA_W-1:0];
    if (cmd.acc_clr) acc <= '0;
    else if (v3)     acc <= acc + prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac1 <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else begin
      mac1 <= cmd.rd_en & cmd.mac;
      v2   <= mac1;
      v3   <= v2;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tree_independence_polynomial.sv =====
// Independence polynomial of a rooted tree given as a preorder level sequence.
// Input channel (in_valid/in_ready): one request per vertex, carrying its
// depth; last marks the final vertex. Output channel (out_valid/out_ready):
// the coefficients of the root polynomial, lowest power first, trailing
// zeros trimmed, final_res on the last one; a malformed sequence gives one
// result with error set instead.
// Sequencing: a non-last vertex is accepted, checked, and opens its level
// with three writes, after closing every level it pops. Closing one level
// reads its parent's lengths, then runs one multiply-accumulate per cycle
// through a single 32x32 multiplier fed by the two stack memories, with a
// drain and a write-back for each output coefficient.
// The last vertex further closes all open levels, scans for trailing zeros
// (a read and a check per coefficient) and emits each coefficient with a
// read followed by a load of the output register.
// Reset clears the run state; the stack memories need no clearing pass.
// A stalled receiver holds the output register and stops the emit
// sequence; a new vertex is taken as soon as the last result is registered.
`default_nettype none
`include "tree_independence_polynomial_defines.svh"
module tree_independence_polynomial (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [4:0]            depth,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4:0]            power,
  output tip_pkg::word_t        coefficient,
  output logic                  error,
  output logic                  final_res
);
  import tip_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_TEST   = 15'b000000000000010,
    S_CLEN   = 15'b000000000000100,
    S_KSTART = 15'b000000000001000,
    S_MAC    = 15'b000000000010000,
    S_DRAIN  = 15'b000000000100000,
    S_WB     = 15'b000000001000000,
    S_OPEN0  = 15'b000000010000000,
    S_OPEN1  = 15'b000000100000000,
    S_OPEN2  = 15'b000001000000000,
    S_TRD    = 15'b000010000000000,
    S_TCHK   = 15'b000100000000000,
    S_ERD    = 15'b001000000000000,
    S_ELD    = 15'b010000000000000,
    S_ERR    = 15'b100000000000000
  } state_t;

  state_t    state;
  tip_cmd_t  cmd;
  word_t     hsum;

  logic [LVL_W-1:0] d_r, od, p_lvl, close_tgt;
  logic             last_r, fin, bad, lvl_open;
  logic [LEN_W-1:0] vcount;
  len_t             lf_t, lg_t, lfp, lgp, lo_f, lo_g, lh, la_sel, lb_sel;
  len_t             lfp_new, lgp_new, lo_f_c, lo_g_c;
  mac_mode_t        phase;
  logic [IDX_W-1:0] k, i, imax, j, imin_c, imax_c;
  logic [1:0]       dcnt;
  logic [4:0]       nlast;
  logic [2*LEN_W-1:0] lenmem [1 << LVL_W];
  logic [2*LEN_W-1:0] len_q;
  logic [LEN_W:0]   k1, diff, sum_f, sum_g;
  logic             in_acc, out_free, bad_hit, need_close;

  tip_store u_store (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .hsum (hsum)
  );

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // level sequence checks against the open state
  always_comb begin
    bad_hit = 1'b0;
    if (vcount >= LEN_W'(MAX_VERTICES)) bad_hit = 1'b1;
    else if (!lvl_open)                 bad_hit = (depth != '0);
    else bad_hit = (depth == '0) || ({1'b0, depth} > ({1'b0, od} + 6'd1));
  end

  assign p_lvl      = od - 5'd1;
  assign close_tgt  = fin ? 5'd1 : d_r;
  assign need_close = lvl_open && (od >= close_tgt);
  assign lh         = (lf_t > lg_t) ? lf_t : lg_t;

  // new parent lengths after a close, capped at NCOEF
  assign lfp_new = len_q[2*LEN_W-1:LEN_W];
  assign lgp_new = len_q[LEN_W-1:0];
  assign sum_f   = {1'b0, lfp_new} + {1'b0, lh} - 7'd1;
  assign sum_g   = {1'b0, lgp_new} + {1'b0, lf_t} - 7'd1;
  assign lo_f_c  = (sum_f > 7'(NCOEF)) ? len_t'(NCOEF) : sum_f[LEN_W-1:0];
  assign lo_g_c  = (sum_g > 7'(NCOEF)) ? len_t'(NCOEF) : sum_g[LEN_W-1:0];

  // term range for output coefficient k
  assign la_sel = (phase == MODE_EXCL) ? lfp : lgp;
  assign lb_sel = (phase == MODE_EXCL) ? lh  : lf_t;
  assign k1     = {1'b0, k} + 7'd1;
  assign diff   = k1 - {1'b0, lb_sel};
  assign imin_c = (k1 > {1'b0, lb_sel}) ? diff[IDX_W-1:0] : '0;
  assign imax_c = (k < la_sel) ? k : la_sel - 6'd1;
  assign j      = k - i;

  // datapath command
  always_comb begin
    cmd      = '0;
    cmd.mode = phase;
    case (state)
      S_KSTART: cmd.acc_clr = 1'b1;
      S_MAC: begin
        cmd.rd_en   = 1'b1;
        cmd.mac     = 1'b1;
        cmd.fa_addr = {p_lvl, i};
        cmd.fb_addr = {od, j};
        cmd.g_addr  = (phase == MODE_EXCL) ? {od, j} : {p_lvl, i};
        cmd.jf      = (j < lf_t);
        cmd.jg      = (j < lg_t);
      end
      S_WB: begin
        cmd.wr_addr = {p_lvl, k};
        cmd.wr_acc  = 1'b1;
        cmd.f_we    = (phase == MODE_EXCL);
        cmd.g_we    = (phase == MODE_INCL);
      end
      S_OPEN0: begin
        cmd.wr_addr = {d_r, 6'd0};
        cmd.wr_one  = 1'b1;
        cmd.f_we    = 1'b1;
      end
      S_OPEN1: begin
        cmd.wr_addr = {d_r, 6'd0};
        cmd.g_we    = 1'b1;
      end
      S_OPEN2: begin
        cmd.wr_addr = {d_r, 6'd1};
        cmd.wr_one  = 1'b1;
        cmd.g_we    = 1'b1;
      end
      S_TRD, S_ERD: begin
        cmd.rd_en   = 1'b1;
        cmd.fb_addr = {5'd0, k};
        cmd.g_addr  = {5'd0, k};
        cmd.jf      = (k < lf_t);
        cmd.jg      = (k < lg_t);
      end
      default: cmd.mode = phase;
    endcase
  end

  // level length memory, read data registered
  always_ff @(posedge clk) begin
    if (state == S_OPEN0 && lvl_open) lenmem[od] <= {lf_t, lg_t};
    if (state == S_TEST) len_q <= lenmem[p_lvl];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl_open  <= 1'b0;
      od        <= '0;
      vcount    <= '0;
      bad       <= 1'b0;
      fin       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // emit states load the output register themselves
      if (out_valid && out_ready && state != S_ELD && state != S_ERR) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            d_r    <= depth;
            last_r <= last;
            if (!bad && bad_hit) bad <= 1'b1;
            state  <= S_TEST;
          end
        end
        S_TEST: begin
          if (bad) begin
            state <= last_r ? S_ERR : S_IDLE;
          end else if (need_close) begin
            state <= S_CLEN;
          end else if (fin) begin
            k     <= lh - 6'd1;
            state <= S_TRD;
          end else begin
            state <= S_OPEN0;
          end
        end
        S_CLEN: begin
          lfp   <= lfp_new;
          lgp   <= lgp_new;
          lo_f  <= lo_f_c;
          lo_g  <= lo_g_c;
          phase <= MODE_EXCL;
          k     <= lo_f_c - 6'd1;
          state <= S_KSTART;
        end
        S_KSTART: begin
          i     <= imin_c;
          imax  <= imax_c;
          state <= S_MAC;
        end
        S_MAC: begin
          if (i == imax) begin
            dcnt  <= 2'd2;
            state <= S_DRAIN;
          end else begin
            i <= i + 6'd1;
          end
        end
        S_DRAIN: begin
          if (dcnt == 2'd0) state <= S_WB;
          else              dcnt  <= dcnt - 2'd1;
        end
        S_WB: begin
          if (k != '0) begin
            k     <= k - 6'd1;
            state <= S_KSTART;
          end else if (phase == MODE_EXCL) begin
            phase <= MODE_INCL;
            k     <= lo_g - 6'd1;
            state <= S_KSTART;
          end else begin
            lf_t  <= lo_f;
            lg_t  <= lo_g;
            od    <= p_lvl;
            state <= S_TEST;
          end
        end
        S_OPEN0: state <= S_OPEN1;
        S_OPEN1: state <= S_OPEN2;
        S_OPEN2: begin
          lf_t     <= 6'd1;
          lg_t     <= 6'd2;
          od       <= d_r;
          lvl_open <= 1'b1;
          vcount   <= vcount + 6'd1;
          if (last_r) begin
            fin   <= 1'b1;
            state <= S_TEST;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TRD: state <= S_TCHK;
        S_TCHK: begin
          if (hsum != '0 || k == '0) begin
            nlast <= (k > 6'd31) ? 5'd31 : k[4:0];
            k     <= '0;
            state <= S_ERD;
          end else begin
            k     <= k - 6'd1;
            state <= S_TRD;
          end
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            power       <= k[4:0];
            coefficient <= hsum;
            error       <= 1'b0;
            final_res   <= (k[4:0] == nlast);
            if (k[4:0] == nlast) begin
              lvl_open <= 1'b0;
              od       <= '0;
              vcount   <= '0;
              bad      <= 1'b0;
              fin      <= 1'b0;
              state    <= S_IDLE;
            end else begin
              k     <= k + 6'd1;
              state <= S_ERD;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            power       <= '0;
            coefficient <= '0;
            error       <= 1'b1;
            final_res   <= 1'b1;
            lvl_open    <= 1'b0;
            od          <= '0;
            vcount      <= '0;
            bad         <= 1'b0;
            fin         <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `TIP_ASSERT_IMP(a_len_range, lvl_open, lf_t != '0 && lg_t != '0 && lh <= len_t'(NCOEF))
  `TIP_ASSERT_IMP(a_err_result, out_valid && error, final_res && coefficient == '0 && power == '0)
  `TIP_ASSERT_IMP(a_vcount_cap, 1'b1, vcount <= LEN_W'(MAX_VERTICES))
  `TIP_ASSERT_NXT(a_final_idle, out_valid && final_res && !$past(out_valid), state == S_IDLE || in_ready == 1'b0)

endmodule
`default_nettype wire

// ===== tb/tree_independence_polynomial_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tree_independence_polynomial_tb;
  import tip_pkg::*;

  localparam int LEVELS     = 32;
  localparam int MAX_OUT    = 32;
  localparam int CYCLE_MAX  = 2000000;
  localparam int ITEM_GOAL  = 170;
  // window with no idling on either side
  localparam int CALM_START = 8000;
  localparam int CALM_END   = 14000;
  // receiver holds off for a long stretch starting here
  localparam int HOLD_START = 1000;
  localparam int HOLD_LEN   = 6000;

  typedef word_t poly_t [NCOEF];

  typedef struct {
    logic [4:0] power;
    word_t      coefficient;
    logic       error;
    logic       final_res;
  } coef_t;

  typedef struct {
    logic [4:0] depth;
    logic       last;
    logic       typed_err;
  } vertex_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [4:0] depth = '0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] power;
  word_t      coefficient;
  logic       error;
  logic       final_res;

  tree_independence_polynomial uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .depth(depth), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .power(power),
    .coefficient(coefficient), .error(error), .final_res(final_res)
  );

  always #5 clk = ~clk;

  // predictor state
  poly_t excl_poly [LEVELS];
  poly_t incl_poly [LEVELS];
  int    excl_len [LEVELS];
  int    incl_len [LEVELS];
  int    top_level;
  bit    any_open;
  int    vertices;
  bit    malformed;

  coef_t coef_q [$];
  int    cycle = 0;
  int    mismatches = 0;
  int    items_sent = 0;
  bit    stim_done = 0;

  // a := a * b, truncated to NCOEF terms, modulo 2^32
  function automatic void poly_mul(inout poly_t a, inout int la, input poly_t b,
                                   input int lb);
    poly_t acc;
    int    lo;
    logic [63:0] prod;
    if (la == 0 || lb == 0) begin
      la = 0;
      return;
    end
    lo = la + lb - 1;
    if (lo > NCOEF) lo = NCOEF;
    foreach (acc[i]) acc[i] = '0;
    for (int i = 0; i < la; i++)
      for (int j = 0; j < lb && i + j < lo; j++) begin
        prod = 64'(a[i]) * 64'(b[j]);
        acc[i+j] = acc[i+j] + prod[31:0];
      end
    a = acc;
    la = lo;
  endfunction

  function automatic int level_sum(input int d, output poly_t h);
    int lh;
    lh = (excl_len[d] > incl_len[d]) ? excl_len[d] : incl_len[d];
    foreach (h[i]) h[i] = '0;
    for (int i = 0; i < lh; i++)
      h[i] = (i < excl_len[d] ? excl_poly[d][i] : '0) +
             (i < incl_len[d] ? incl_poly[d][i] : '0);
    return lh;
  endfunction

  // fold level d into its parent
  function automatic void fold_level(input int d);
    poly_t h;
    int    lh;
    lh = level_sum(d, h);
    poly_mul(excl_poly[d-1], excl_len[d-1], h, lh);
    poly_mul(incl_poly[d-1], incl_len[d-1], excl_poly[d], excl_len[d]);
  endfunction

  function automatic void clear_run();
    top_level = 0;
    any_open  = 0;
    vertices  = 0;
    malformed = 0;
  endfunction

  // advance the tree state by one vertex; returns the coefficients it releases
  function automatic void predict_vertex(input logic [4:0] d_in, input logic last_in,
                                         output coef_t res [$]);
    int    d;
    poly_t h;
    int    n;
    coef_t c;
    d = d_in;
    res = {};
    if (!malformed) begin
      if (vertices >= MAX_VERTICES) malformed = 1;
      else if (!any_open) begin
        if (d != 0) malformed = 1;
      end else if (d == 0 || d > top_level + 1) malformed = 1;
    end
    if (!malformed) begin
      while (any_open && top_level >= d) begin
        fold_level(top_level);
        top_level--;
      end
      for (int i = 0; i < NCOEF; i++) begin
        excl_poly[d][i] = '0;
        incl_poly[d][i] = '0;
      end
      excl_poly[d][0] = 1;
      incl_poly[d][1] = 1;
      excl_len[d] = 1;
      incl_len[d] = 2;
      top_level = d;
      any_open = 1;
      vertices++;
    end
    if (!last_in) return;
    if (malformed || !any_open) begin
      c = '{power: '0, coefficient: '0, error: 1'b1, final_res: 1'b1};
      res.push_back(c);
      clear_run();
      return;
    end
    while (top_level >= 1) begin
      fold_level(top_level);
      top_level--;
    end
    n = level_sum(0, h);
    while (n > 1 && h[n-1] == 0) n--;
    if (n == 0) n = 1;
    if (n > MAX_OUT) n = MAX_OUT;
    for (int k = 0; k < n; k++) begin
      c = '{power: 5'(k), coefficient: h[k], error: 1'b0, final_res: (k + 1 == n)};
      res.push_back(c);
    end
    clear_run();
  endfunction

  function automatic bit calm();
    return cycle >= CALM_START && cycle < CALM_END;
  endfunction

  // present one request and wait for it to be taken
  task automatic send_vertex(input logic [4:0] d, input logic l, input bit typed_err);
    coef_t res [$];
    while (!calm() && $urandom_range(99) < 36) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    depth    <= d;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    predict_vertex(d, l, res);
    if (typed_err)
      coef_q.push_back('{power: '0, coefficient: '0, error: 1'b1, final_res: 1'b1});
    else
      foreach (res[i]) coef_q.push_back(res[i]);
    items_sent++;
  endtask

  // directed part: small trees and malformed depth cases
  vertex_row_t directed [] = '{
    '{5'd0, 1'b1, 1'b0},                                   // lone root
    '{5'd0, 1'b0, 1'b0}, '{5'd1, 1'b0, 1'b0},
    '{5'd2, 1'b0, 1'b0}, '{5'd3, 1'b1, 1'b0},              // path
    '{5'd0, 1'b0, 1'b0}, '{5'd1, 1'b0, 1'b0}, '{5'd1, 1'b0, 1'b0},
    '{5'd2, 1'b0, 1'b0}, '{5'd1, 1'b1, 1'b0},              // branching
    '{5'd31, 1'b1, 1'b1},                                  // nonzero first depth
    '{5'd0, 1'b0, 1'b0}, '{5'd0, 1'b1, 1'b1},              // second root
    '{5'd0, 1'b0, 1'b0}, '{5'd2, 1'b0, 1'b0},
    '{5'd1, 1'b0, 1'b0}, '{5'd1, 1'b1, 1'b1}               // depth jump, then ignored
  };

  // random trees, mostly well formed
  task automatic send_random_tree();
    int kind, size, cur, d;
    kind = $urandom_range(99);
    if (kind < 65) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 8);
      cur = 0;
      for (int i = 0; i < size; i++) begin
        d = (i == 0) ? 0 : $urandom_range(1, (cur + 1 > 31) ? 31 : cur + 1);
        send_vertex(5'(d), i == size - 1, 1'b0);
        cur = d;
      end
    end else if (kind < 75) begin
      // deepest path
      for (int i = 0; i < 32; i++) send_vertex(5'(i), i == 31, 1'b0);
    end else if (kind < 85) begin
      // one vertex too many
      for (int i = 0; i < 33; i++)
        send_vertex((i == 0) ? 5'd0 : 5'($urandom_range(1, 2)), i == 32, 1'b0);
    end else begin
      size = $urandom_range(1, 6);
      for (int i = 0; i < size; i++)
        send_vertex(5'($urandom_range(31)), i == size - 1, 1'b0);
    end
  endtask

  // stimulus
  initial begin
    clear_run();
    foreach (excl_len[i]) begin
      excl_len[i] = 0;
      incl_len[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_vertex(directed[i].depth, directed[i].last,
                                      directed[i].typed_err);
    while (items_sent < ITEM_GOAL) send_random_tree();
    @(negedge clk);
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (cycle == HOLD_START) hold = HOLD_LEN;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else
        out_ready <= rst ? 1'b0 : (calm() || $urandom_range(99) >= 36);
    end
  end

  // result checker
  always @(posedge clk) begin
    coef_t exp_c;
    if (!rst && out_valid && out_ready) begin
      if (coef_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: power %0d coefficient %0d error %0b final %0b",
                   power, coefficient, error, final_res);
      end else begin
        exp_c = coef_q.pop_front();
        if (power !== exp_c.power || coefficient !== exp_c.coefficient ||
            error !== exp_c.error || final_res !== exp_c.final_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected p=%0d c=%0d e=%0b f=%0b got p=%0d c=%0d e=%0b f=%0b",
                     exp_c.power, exp_c.coefficient, exp_c.error, exp_c.final_res,
                     power, coefficient, error, final_res);
        end
      end
    end
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_MAX) begin
      $display("tree_independence_polynomial_tb: FAIL");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (coef_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && coef_q.size() == 0)
      $display("tree_independence_polynomial_tb: PASS");
    else
      $display("tree_independence_polynomial_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
